>>> sv/squared_distance_transform_defines.svh
// Assertion macros shared by the squared distance transform RTL.
// Included by modules that carry concurrent checks.
`ifndef SQUARED_DISTANCE_TRANSFORM_DEFINES_SVH
`define SQUARED_DISTANCE_TRANSFORM_DEFINES_SVH

// Same-cycle implication check.
`define SDT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdt check failed");

// Next-cycle implication check.
`define SDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdt check failed");

`endif

>>> sv/sdt_pkg.sv
// Shared types and constants for the squared distance transform.
// No dependencies.
package sdt_pkg;

    localparam int SDT_MAX_WIDTH  = 64;
    localparam int SDT_MAX_HEIGHT = 64;

    localparam int WIDTH_W = 7;
    localparam int BPP_W   = 3;
    localparam int CHAN_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int PIXEL_W = 32;
    localparam int LEVEL_W = 8;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [WIDTH_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [BPP_W-1:0]   BPP_RESET    = 3'd1;
    localparam logic [CHAN_W-1:0]  CHAN_RESET   = 2'd0;

    // item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BPP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN   = 3'd3;

    // controller phases, also the datapath command
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PH_W-1:0] PH_FWD_RD    = 4'd1;
    localparam logic [PH_W-1:0] PH_FWD_WR    = 4'd2;
    localparam logic [PH_W-1:0] PH_BWD_RD    = 4'd3;
    localparam logic [PH_W-1:0] PH_BWD_WR    = 4'd4;
    localparam logic [PH_W-1:0] PH_END0      = 4'd5;
    localparam logic [PH_W-1:0] PH_END1      = 4'd6;
    localparam logic [PH_W-1:0] PH_COL_RUN   = 4'd7;
    localparam logic [PH_W-1:0] PH_COL_DRAIN = 4'd8;
    localparam logic [PH_W-1:0] PH_COL_WR    = 4'd9;
    localparam logic [PH_W-1:0] PH_RD_WAIT   = 4'd10;
    localparam logic [PH_W-1:0] PH_RD_DIV    = 4'd11;
    localparam logic [PH_W-1:0] PH_RD_OUT    = 4'd12;

    typedef struct packed {
        logic [PH_W-1:0] phase;
    } sdt_cmd_t;

    typedef struct packed {
        logic start_row;
        logic start_read;
        logic x_end;
        logic x_one;
        logic y_last;
        logic r_last;
        logic k_zero;
        logic out_free;
    } sdt_status_t;

endpackage

>>> sv/sdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sdt_ctrl.sv
// Phase sequencer for the squared distance transform.
// Depends on sdt_pkg.
module sdt_ctrl
    import sdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sdt_status_t status,
    output sdt_cmd_t    cmd,
    output logic        idle
);

    logic [PH_W-1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            PH_IDLE: begin
                if (status.start_row) begin
                    state_next = PH_FWD_RD;
                end else if (status.start_read) begin
                    state_next = PH_RD_WAIT;
                end
            end
            PH_FWD_RD:    state_next = PH_FWD_WR;
            PH_FWD_WR:    state_next = status.x_end ? PH_BWD_RD : PH_FWD_RD;
            PH_BWD_RD:    state_next = PH_BWD_WR;
            PH_BWD_WR:    state_next = status.x_one ? PH_END0 : PH_BWD_RD;
            PH_END0:      state_next = PH_END1;
            PH_END1:      state_next = status.y_last ? PH_COL_RUN : PH_FWD_RD;
            PH_COL_RUN:   state_next = status.r_last ? PH_COL_DRAIN : PH_COL_RUN;
            PH_COL_DRAIN: state_next = PH_COL_WR;
            PH_COL_WR: begin
                state_next = (status.y_last && status.x_end) ? PH_IDLE : PH_COL_RUN;
            end
            PH_RD_WAIT:   state_next = PH_RD_DIV;
            PH_RD_DIV:    state_next = status.k_zero ? PH_RD_OUT : PH_RD_DIV;
            PH_RD_OUT:    state_next = status.out_free ? PH_IDLE : PH_RD_OUT;
            default:      state_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.phase = state_reg;
    assign idle      = (state_reg == PH_IDLE);

endmodule

>>> sv/sdt_datapath.sv
// Counters, stores, row/column passes, divider and output register.
// Depends on sdt_pkg, sdt_ram and the assertion macro header.
`include "squared_distance_transform_defines.svh"
module sdt_datapath
    import sdt_pkg::*;
#(
    parameter int MAX_WIDTH  = SDT_MAX_WIDTH,
    parameter int MAX_HEIGHT = SDT_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdt_cmd_t              cmd,
    output sdt_status_t           status,
    input  logic                  s_fire,
    input  logic                  s_kind,
    input  logic [PIXEL_W-1:0]    s_word,
    input  logic                  cfg_fire,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [LEVEL_W-1:0]    m_level,
    output logic                  m_last
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RUN_W  = W_W;
    localparam int DIST_W = 2 * RUN_W;
    localparam int SUM_W  = ((2 * Y_W > DIST_W) ? 2 * Y_W : DIST_W) + 1;
    localparam int NUM_W  = DIST_W + LEVEL_W;
    localparam int K_W    = $clog2(LEVEL_W);

    // configuration
    logic [WIDTH_W-1:0] width_reg, height_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [CHAN_W-1:0]  chan_reg;

    logic [W_W-1:0]   w_eff;
    logic [H_W-1:0]   h_eff;
    logic [BPP_W-1:0] bpp_eff;
    logic [CNT_W-1:0] total;
    logic [X_W-1:0]   wm2;
    logic [Y_W-1:0]   hm1;

    always_comb begin
        if (width_reg < 3) begin
            w_eff = W_W'(3);
        end else if (width_reg > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(width_reg);
        end
        if (height_reg < 1) begin
            h_eff = H_W'(1);
        end else if (height_reg > MAX_HEIGHT) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(height_reg);
        end
        if (bpp_reg < 1) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > 4) begin
            bpp_eff = BPP_W'(4);
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    assign total = CNT_W'(w_eff * h_eff);
    assign wm2   = X_W'(w_eff - W_W'(2));
    assign hm1   = Y_W'(h_eff - H_W'(1));

    // load / read bookkeeping
    logic [CNT_W-1:0]  load_cnt_reg, read_cnt_reg;
    logic [CNT_W-1:0]  load_pos, load_next, read_pos, read_next;
    logic              load_done, read_ok, read_last;
    logic [7:0]        tested_byte;
    logic              feature;
    logic              load_fire, read_fire;

    assign load_fire = s_fire && (s_kind == OP_LOAD);
    assign read_fire = s_fire && (s_kind == OP_READ);
    assign load_pos  = (load_cnt_reg >= total) ? '0 : load_cnt_reg;
    assign load_next = load_pos + CNT_W'(1);
    assign load_done = (load_next == total);
    assign read_ok   = (load_cnt_reg == total);
    assign read_pos  = (read_cnt_reg >= total) ? '0 : read_cnt_reg;
    assign read_last = (read_pos + CNT_W'(1) == total);
    assign read_next = read_last ? '0 : read_pos + CNT_W'(1);
    assign tested_byte = ({1'b0, chan_reg} < bpp_eff) ?
                         8'(s_word >> {chan_reg, 3'b000}) : 8'd0;
    assign feature = (tested_byte == 8'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            bpp_reg      <= BPP_RESET;
            chan_reg     <= CHAN_RESET;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_BPP:    bpp_reg    <= BPP_W'(cfg_data);
                REG_CHAN:   chan_reg   <= CHAN_W'(cfg_data);
                default: ;
            endcase
            if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                cfg_index == REG_BPP || cfg_index == REG_CHAN) begin
                load_cnt_reg <= '0;
                read_cnt_reg <= '0;
            end
        end else if (load_fire) begin
            load_cnt_reg <= load_next;
            if (load_cnt_reg >= total) begin
                read_cnt_reg <= '0;
            end
        end else if (read_fire && read_ok) begin
            read_cnt_reg <= read_next;
        end
    end

    // transform counters
    logic [Y_W-1:0]    y_reg, r_reg, r_d_reg;
    logic [X_W-1:0]    x_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [ADDR_W-1:0] base_reg, pix_reg, col_reg;
    logic              v_d_reg;
    logic [SUM_W-1:0]  min_reg;
    logic [DIST_W-1:0] largest_reg;

    logic [DIST_W-1:0] row_rdata, dist_rdata;
    logic [RUN_W-1:0]  fwd_rdata;
    logic              row_feat;
    logic [RUN_W-1:0]  run_step, run_min;
    logic [Y_W-1:0]    gap;
    logic [SUM_W-1:0]  cand;
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] w_addr;

    assign w_addr   = ADDR_W'(w_eff);
    assign row_addr = base_reg + ADDR_W'(x_reg);
    assign row_feat = (row_rdata != '0);
    assign run_step = row_feat ? '0 : run_reg + RUN_W'(1);
    assign run_min  = (run_step < fwd_rdata) ? run_step : fwd_rdata;
    assign gap      = (r_d_reg > y_reg) ? r_d_reg - y_reg : y_reg - r_d_reg;
    assign cand     = SUM_W'(gap * gap) + SUM_W'(row_rdata);

    // row store ports
    logic              row_we, row_re;
    logic [ADDR_W-1:0] row_waddr, row_raddr;
    logic [DIST_W-1:0] row_wdata;

    always_comb begin
        row_we    = 1'b0;
        row_waddr = row_addr;
        row_wdata = DIST_W'(run_min * run_min);
        if (cmd.phase == PH_IDLE && load_fire) begin
            row_we    = 1'b1;
            row_waddr = load_pos[ADDR_W-1:0];
            row_wdata = feature ? DIST_W'(1) : '0;
        end else if (cmd.phase == PH_BWD_WR) begin
            row_we = 1'b1;
        end
    end

    assign row_re    = (cmd.phase == PH_FWD_RD) || (cmd.phase == PH_BWD_RD) ||
                       (cmd.phase == PH_COL_RUN);
    assign row_raddr = (cmd.phase == PH_COL_RUN) ? col_reg : row_addr;

    // distance store ports
    logic              dist_we;
    logic [ADDR_W-1:0] dist_waddr;
    logic [DIST_W-1:0] dist_wdata;

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = base_reg;
        dist_wdata = '0;
        unique case (cmd.phase)
            PH_END0: dist_we = 1'b1;
            PH_END1: begin
                dist_we    = 1'b1;
                dist_waddr = base_reg + w_addr - ADDR_W'(1);
            end
            PH_COL_WR: begin
                dist_we    = 1'b1;
                dist_waddr = pix_reg;
                dist_wdata = DIST_W'(min_reg);
            end
            default: ;
        endcase
    end

    sdt_ram #(.WIDTH(DIST_W), .DEPTH(DEPTH)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    sdt_ram #(.WIDTH(DIST_W), .DEPTH(DEPTH)) u_dist_ram (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .re    (read_fire && read_ok),
        .raddr (read_pos[ADDR_W-1:0]),
        .rdata (dist_rdata)
    );

    sdt_ram #(.WIDTH(RUN_W), .DEPTH(MAX_WIDTH)) u_fwd_ram (
        .aclk  (aclk),
        .we    (cmd.phase == PH_FWD_WR),
        .waddr (x_reg),
        .wdata (run_step),
        .re    (cmd.phase == PH_BWD_RD),
        .raddr (x_reg),
        .rdata (fwd_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            largest_reg <= '0;
            v_d_reg     <= 1'b0;
        end else begin
            v_d_reg <= (cmd.phase == PH_COL_RUN);
            if (cmd.phase == PH_IDLE && load_fire && load_done) begin
                largest_reg <= '0;
            end else if (cmd.phase == PH_COL_WR && DIST_W'(min_reg) > largest_reg) begin
                largest_reg <= DIST_W'(min_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_d_reg <= r_reg;
        if (v_d_reg && cand < min_reg) begin
            min_reg <= cand;
        end
        unique case (cmd.phase)
            PH_IDLE: begin
                y_reg    <= '0;
                base_reg <= '0;
                x_reg    <= X_W'(1);
                run_reg  <= '0;
            end
            PH_FWD_WR: begin
                if (x_reg == wm2) begin
                    run_reg <= '0;
                end else begin
                    run_reg <= run_step;
                    x_reg   <= x_reg + X_W'(1);
                end
            end
            PH_BWD_WR: begin
                run_reg <= run_step;
                x_reg   <= x_reg - X_W'(1);
            end
            PH_END1: begin
                x_reg   <= X_W'(1);
                run_reg <= '0;
                r_reg   <= '0;
                min_reg <= '1;
                if (y_reg == hm1) begin
                    y_reg   <= '0;
                    pix_reg <= ADDR_W'(1);
                    col_reg <= ADDR_W'(1);
                end else begin
                    y_reg    <= y_reg + Y_W'(1);
                    base_reg <= base_reg + w_addr;
                end
            end
            PH_COL_RUN: begin
                col_reg <= col_reg + w_addr;
                r_reg   <= r_reg + Y_W'(1);
            end
            PH_COL_WR: begin
                min_reg <= '1;
                r_reg   <= '0;
                if (y_reg == hm1) begin
                    x_reg   <= x_reg + X_W'(1);
                    y_reg   <= '0;
                    pix_reg <= ADDR_W'(x_reg) + ADDR_W'(1);
                    col_reg <= ADDR_W'(x_reg) + ADDR_W'(1);
                end else begin
                    y_reg   <= y_reg + Y_W'(1);
                    pix_reg <= pix_reg + w_addr;
                    col_reg <= ADDR_W'(x_reg);
                end
            end
            default: ;
        endcase
    end

    // scaling divider: one quotient bit per cycle
    logic [NUM_W-1:0]   rem_reg, trial;
    logic [DIST_W-1:0]  den_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [K_W-1:0]     k_reg;
    logic               last_reg;

    assign trial = NUM_W'(den_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.phase == PH_IDLE && read_fire) begin
            last_reg <= read_last;
        end
        if (cmd.phase == PH_RD_WAIT) begin
            rem_reg <= {dist_rdata, LEVEL_W'(0)} - NUM_W'(dist_rdata);
            den_reg <= largest_reg;
            q_reg   <= '0;
            k_reg   <= K_W'(LEVEL_W - 1);
        end else if (cmd.phase == PH_RD_DIV) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                q_reg   <= q_reg | (LEVEL_W'(1) << k_reg);
            end
            k_reg <= k_reg - K_W'(1);
        end
    end

    // output register
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_last_reg;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.phase == PH_RD_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.phase == PH_RD_OUT && out_free) begin
            m_level_reg <= (den_reg == '0) ? '0 : q_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_level  = m_level_reg;
    assign m_last   = m_last_reg;

    assign status.start_row  = load_fire && load_done;
    assign status.start_read = read_fire && read_ok;
    assign status.x_end      = (x_reg == wm2);
    assign status.x_one      = (x_reg == X_W'(1));
    assign status.y_last     = (y_reg == hm1);
    assign status.r_last     = (r_reg == hm1);
    assign status.k_zero     = (k_reg == '0);
    assign status.out_free   = out_free;

    `SDT_ASSERT_NOW(a_load_range, aclk, aresetn, 1'b1, load_cnt_reg <= total)
    `SDT_ASSERT_NOW(a_read_range, aclk, aresetn, 1'b1, read_cnt_reg < total)
    `SDT_ASSERT_NEXT(a_largest_tracks, aclk, aresetn, cmd.phase == PH_COL_WR,
        largest_reg >= DIST_W'($past(min_reg)))

endmodule

>>> sv/squared_distance_transform.sv
// Squared distance transform top level: a read result passes through the store read,
// 8 divide steps and the output register, and waits while the output is not free.
// No new item is taken until the controller is idle again. The load that completes
// the image starts the transform, whose column pass reads one row entry per cycle.
// Reset is synchronous: the configuration registers go to their defaults and the
// counts clear. The stores keep their contents.
module squared_distance_transform
    import sdt_pkg::*;
#(
    parameter int MAX_WIDTH  = SDT_MAX_WIDTH,
    parameter int MAX_HEIGHT = SDT_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [31:0] pixel_word
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [LEVEL_W-1:0]    m_tdata,   // [7:0] level
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sdt_cmd_t    cmd;
    sdt_status_t status;
    logic        idle;

    assign s_tready  = idle;
    assign cfg_ready = idle;

    sdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd),
        .idle    (idle)
    );

    sdt_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_fire    (s_tvalid && s_tready),
        .s_kind    (s_tuser),
        .s_word    (s_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_level   (m_tdata),
        .m_last    (m_tlast)
    );

endmodule

>>> dv/testbench.sv
// Testbench for squared_distance_transform: drives images in and reads the
// scaled distances back, checking each transfer against a built-in predictor.
// Depends on sdt_pkg and the squared_distance_transform RTL.
module testbench;
    import sdt_pkg::*;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_t;

    class distance_scoreboard;
        int unsigned width_reg, height_reg, bpp_reg, chan_reg;
        int unsigned feature_row [4096];
        int unsigned row_dist [4096];
        int unsigned final_dist [4096];
        int unsigned largest, loaded, read_pos;
        level_t expected_levels [$];
        int errors;

        function new();
            width_reg = 64; height_reg = 64; bpp_reg = 1; chan_reg = 0;
            largest = 0; loaded = 0; read_pos = 0; errors = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned cols();
            return clamp(width_reg, 3, SDT_MAX_WIDTH);
        endfunction

        function int unsigned rows();
            return clamp(height_reg, 1, SDT_MAX_HEIGHT);
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg = data;
                REG_HEIGHT: height_reg = data;
                REG_BPP:    bpp_reg = data[BPP_W-1:0];
                REG_CHAN:   chan_reg = data[CHAN_W-1:0];
                default:    return;
            endcase
            loaded = 0;
            read_pos = 0;
        endfunction

        function void transform(int unsigned w, int unsigned h);
            int unsigned fwd [64];
            int unsigned run, b, d, c, gap, base;
            for (int unsigned y = 0; y < h; y++) begin
                base = y * w;
                run = 0;
                fwd[0] = 0;
                for (int unsigned x = 1; x + 1 < w; x++) begin
                    run++;
                    if (feature_row[base + x] != 0) run = 0;
                    fwd[x] = run * run;
                end
                run = 0;
                for (int unsigned x = w - 2; x > 0; x--) begin
                    run++;
                    if (feature_row[base + x] != 0) run = 0;
                    b = run * run;
                    row_dist[base + x] = (b < fwd[x]) ? b : fwd[x];
                end
                row_dist[base] = 0;
                row_dist[base + w - 1] = 0;
            end
            largest = 0;
            for (int unsigned y = 0; y < h; y++) begin
                final_dist[y * w] = 0;
                final_dist[y * w + w - 1] = 0;
            end
            for (int unsigned x = 1; x + 1 < w; x++) begin
                for (int unsigned y = 0; y < h; y++) begin
                    d = row_dist[y * w + x];
                    for (int unsigned r = 0; r < h; r++) begin
                        gap = (r > y) ? r - y : y - r;
                        c = gap * gap + row_dist[r * w + x];
                        if (c < d) d = c;
                    end
                    final_dist[y * w + x] = d;
                    if (d > largest) largest = d;
                end
            end
        endfunction

        function void note_input(logic op, logic [PIXEL_W-1:0] word);
            int unsigned total, bpp;
            logic [7:0] tested;
            level_t lv;
            total = cols() * rows();
            if (op == OP_LOAD) begin
                bpp = clamp(bpp_reg, 1, 4);
                tested = 8'd0;
                if (loaded >= total) begin
                    loaded = 0;
                    read_pos = 0;
                end
                if (chan_reg < bpp) tested = word[8 * chan_reg +: 8];
                feature_row[loaded] = (tested == 8'd0);
                loaded++;
                if (loaded == total) transform(cols(), rows());
                return;
            end
            // reads before the image is complete are dropped
            if (loaded != total) return;
            if (read_pos >= total) read_pos = 0;
            lv.level = (largest == 0) ? 8'd0 : 8'((64'(final_dist[read_pos]) * 255) / largest);
            lv.last = (read_pos + 1 == total);
            expected_levels.push_back(lv);
            read_pos++;
            if (read_pos >= total) read_pos = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [LEVEL_W-1:0] level, logic last);
            level_t exp_lv;
            if (expected_levels.size() == 0) begin
                report($sformatf("unexpected level %0d last %0b", level, last));
                return;
            end
            exp_lv = expected_levels.pop_front();
            if (level !== exp_lv.level)
                report($sformatf("level %0d, expected %0d", level, exp_lv.level));
            if (last !== exp_lv.last)
                report($sformatf("last %0b, expected %0b", last, exp_lv.last));
        endtask

        function int unsigned settle_cycles();
            int unsigned w, h;
            w = cols();
            h = rows();
            return 2 * (h * (4 * (w - 2) + 2) + (w - 2) * h * (h + 2)) + 200;
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [LEVEL_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    distance_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    logic steady = 1'b0;

    squared_distance_transform uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 30);
    end

    task automatic send_item(logic op, logic [PIXEL_W-1:0] word);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 30) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = word;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // hold until every level has come back and a transform would have finished
    task automatic drain();
        stop_sending();
        while (sb.expected_levels.size() != 0) @(posedge aclk);
        repeat (sb.settle_cycles()) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.configure(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] word;
        word = $urandom;
        for (int i = 0; i < 4; i++)
            if ($urandom_range(99) < 30) word[8 * i +: 8] = 8'd0;
        return word;
    endfunction

    task automatic load_image(int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_item(OP_LOAD, random_pixel());
    endtask

    task automatic read_levels(int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_item(OP_READ, $urandom);
    endtask

    task automatic random_setting();
        int unsigned pick, w, h;
        logic [CFG_DATA_W-1:0] vals [4];
        pick = $urandom_range(99);
        w = $urandom_range(3, 10);
        h = $urandom_range(1, 8);
        if (pick < 6) begin
            w = (pick < 3) ? 64 : (($urandom_range(1)) ? 127 : $urandom_range(0, 2));
            h = $urandom_range(1, 2);
        end else if (pick < 10) begin
            w = $urandom_range(3, 4);
            h = (pick < 8) ? 64 : (($urandom_range(1)) ? 127 : 0);
        end
        vals[0] = CFG_DATA_W'(w);
        vals[1] = CFG_DATA_W'(h);
        vals[2] = CFG_DATA_W'($urandom_range(0, 7));
        vals[3] = CFG_DATA_W'($urandom_range(0, 3));
        for (int i = 0; i < 4; i++)
            if (i < 2 || $urandom_range(99) < 70) write_reg(CFG_IDX_W'(i), vals[i]);
        if ($urandom_range(99) < 5)
            write_reg(CFG_IDX_W'($urandom_range(4, 7)), CFG_DATA_W'($urandom));
    endtask

    initial begin
        int unsigned total;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // read before any image is complete
        send_item(OP_READ, '1);
        drain();
        write_reg(REG_WIDTH, 7'd5);
        write_reg(REG_HEIGHT, 7'd3);
        write_reg(REG_BPP, 7'd2);
        write_reg(REG_CHAN, 7'd1);
        for (int i = 0; i < 15; i++)
            send_item(OP_LOAD, (i % 4 == 0) ? 32'h0000_0000 :
                               (i % 4 == 1) ? 32'hFFFF_FFFF :
                               (i % 4 == 2) ? 32'h0000_FF00 : 32'hFFFF_00FF);
        read_levels(17);    // runs past the last pixel and wraps
        // channel beyond the valid bytes: every pixel is a feature
        drain();
        write_reg(REG_CHAN, 7'd3);
        load_image(15);
        read_levels(3);
        send_item(OP_LOAD, '1);   // load after complete starts over
        drain();

        while (items_sent < 1300) begin
            random_setting();
            total = sb.cols() * sb.rows();
            if (items_sent > 500 && items_sent < 800) steady = 1'b1;
            else steady = 1'b0;
            if ($urandom_range(99) < 85) begin
                for (int unsigned i = 0; i < total; i++) begin
                    if ($urandom_range(99) < 3) send_item(OP_READ, $urandom);
                    send_item(OP_LOAD, random_pixel());
                end
                read_levels($urandom_range(total / 2, 2 * total + 1));
                if (total <= 80 && $urandom_range(99) < 25) begin
                    load_image(total);
                    read_levels($urandom_range(1, total + 2));
                end
            end else begin
                load_image($urandom_range(1, total));
                read_levels($urandom_range(1, 4));
            end
            drain();
        end

        steady = 1'b0;
        drain();
        for (int i = 0; i < sb.expected_levels.size(); i++)
            sb.report("level never arrived");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
